// ----- src/qti_pkg.sv -----
// ----------------------------------------------------------------------------
// qti_pkg
// Shared types, codes and defaults of the quadrilinear table interpolator.
// ----------------------------------------------------------------------------
package qti_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 9;   // point counts up to 256
	localparam int IDX_W  = 8;   // axis point index
	localparam int CFG_IDX_W = 3;

	localparam int DEF_NUM_TABLES        = 4;
	localparam int DEF_MAX_ANGLE_POINTS  = 16;
	localparam int DEF_MAX_ALBEDO_POINTS = 4;
	localparam int DEF_MAX_OZONE_POINTS  = 8;
	localparam int DEF_MAX_HEIGHT_POINTS = 16;
	localparam int DEF_WEIGHT_BITS       = 16;

	localparam logic [1:0] ACT_QUERY = 2'd0;
	localparam logic [1:0] ACT_AXIS  = 2'd1;
	localparam logic [1:0] ACT_TABLE = 2'd2;

	localparam logic [1:0] AXIS_ANGLE  = 2'd0;
	localparam logic [1:0] AXIS_ALBEDO = 2'd1;
	localparam logic [1:0] AXIS_OZONE  = 2'd2;
	localparam logic [1:0] AXIS_HEIGHT = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_CUTOFF  = 2'd1;
	localparam logic [1:0] STAT_NOTABLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_POINTS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALBEDO_POINTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OZONE_POINTS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_POINTS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CUTOFF  = 3'd4;

	localparam logic [4:0]        RST_ANGLE_POINTS  = 5'd16;
	localparam logic [2:0]        RST_ALBEDO_POINTS = 3'd4;
	localparam logic [3:0]        RST_OZONE_POINTS  = 4'd8;
	localparam logic [4:0]        RST_HEIGHT_POINTS = 5'd16;
	localparam logic signed [31:0] RST_ANGLE_CUTOFF = 32'sd5898240;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_DIV,
		ST_RD,
		ST_WAIT,
		ST_MERGE,
		ST_BLEND
	} state_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         table_select;
		logic [1:0]         axis_select;
		logic [12:0]        entry_index;
		logic signed [31:0] write_value;
		logic signed [31:0] angle_coord;
		logic signed [31:0] albedo_coord;
		logic signed [31:0] ozone_coord;
		logic signed [31:0] height_coord;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic [1:0]         status;
	} result_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [4:0] n, input int max);
		logic [CNT_W-1:0] r;
		if (n < 5'd2) r = CNT_W'(2);
		else if (int'(n) > max) r = CNT_W'(max);
		else r = CNT_W'(n);
		return r;
	endfunction

endpackage

// ----- src/qti_div.sv -----
// ----------------------------------------------------------------------------
// qti_div
// Restoring divider, one quotient bit per cycle: floor((num << WB) / den),
// for 0 < num < den.
// ----------------------------------------------------------------------------
module qti_div #(
	parameter int WB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [32:0]   num,
	input  logic [32:0]   den,
	output logic          done,
	output logic [WB-1:0] quo
);
	localparam int CW = $clog2(WB + 1);

	logic [33:0]   rem_q;
	logic [32:0]   den_q;
	logic [WB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [33:0]   trial;

	assign trial = {rem_q[32:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[WB-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[WB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- src/qti_blend.sv -----
// ----------------------------------------------------------------------------
// qti_blend
// Shared blend unit: y = a + floor((b - a) * w / 2^WB); product and result are registered.
// ----------------------------------------------------------------------------
module qti_blend #(
	parameter int WB = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic [WB:0]        w,
	output logic               done,
	output logic signed [31:0] y
);
	localparam int PW = 33 + WB + 2;

	logic signed [31:0] a_q;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] shifted;
	logic signed [32:0] diff;
	logic signed [WB+1:0] ws;
	logic signed [31:0] y_q;
	logic run_s1;
	logic done_q;

	assign diff    = 33'(b) - 33'(a);
	assign ws      = {1'b0, w};
	assign shifted = prod_s1 >>> WB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_s1 <= go;
			done_q <= run_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q     <= a;
			prod_s1 <= PW'(diff) * PW'(ws);
		end
		if (run_s1) y_q <= a_q + shifted[31:0];
	end

	assign done = done_q;
	assign y    = y_q;
endmodule

// ----- src/qti_ram.sv -----
// ----------------------------------------------------------------------------
// qti_ram
// Value table store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qti_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [31:0]       wdata,
	input  logic [AW-1:0]     raddr,
	output logic [31:0]       rdata
);
	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/quadrilinear_table_interpolator_core.sv -----
// ----------------------------------------------------------------------------
// quadrilinear_table_interpolator_core
// Four-axis table lookup with per-axis linear blending.
// ----------------------------------------------------------------------------
// Usage:
//   cmd is taken when start is high and busy is low. Axis and table writes
//   complete at that edge, produce no result and never raise busy.
//   An interpolating query raises busy until its result; done pulses for
//   one cycle with result valid. The receiver cannot stall, so a result
//   is never held. Cutoff and missing-table queries answer in the next cycle.
//   An interpolating query runs on one sequencer: per axis a linear scan
//   (one axis point per cycle) and, when the point lies strictly inside a
//   bracket, a serial division; then 16 corner reads through the single
//   table read port and 15 blends on the shared multiplier.
//   Configuration writes (cfg_we) are taken at any edge and should only
//   be issued while idle. Reset loads default counts and cutoff and
//   clears table-written flags; axis points and table values are unset.
// ----------------------------------------------------------------------------
module quadrilinear_table_interpolator_core
	import qti_pkg::*;
#(
	parameter int NUM_TABLES        = DEF_NUM_TABLES,
	parameter int MAX_ANGLE_POINTS  = DEF_MAX_ANGLE_POINTS,
	parameter int MAX_ALBEDO_POINTS = DEF_MAX_ALBEDO_POINTS,
	parameter int MAX_OZONE_POINTS  = DEF_MAX_OZONE_POINTS,
	parameter int MAX_HEIGHT_POINTS = DEF_MAX_HEIGHT_POINTS,
	parameter int WEIGHT_BITS       = DEF_WEIGHT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);
	localparam int TABLE_SIZE = MAX_ANGLE_POINTS * MAX_ALBEDO_POINTS *
		MAX_OZONE_POINTS * MAX_HEIGHT_POINTS;
	localparam int MEM_DEPTH = NUM_TABLES * TABLE_SIZE;
	localparam int MAW = $clog2(MEM_DEPTH);
	localparam int TW  = $clog2(TABLE_SIZE);
	localparam int TSW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int ANG_AW = $clog2(MAX_ANGLE_POINTS);
	localparam int ALB_AW = $clog2(MAX_ALBEDO_POINTS);
	localparam int OZN_AW = $clog2(MAX_OZONE_POINTS);
	localparam int HGT_AW = $clog2(MAX_HEIGHT_POINTS);
	localparam int WB = WEIGHT_BITS;
	localparam logic [WB:0] W_ONE = (WB+1)'(1) << WB;

	// configuration
	logic [4:0] ang_pts_q;
	logic [2:0] alb_pts_q;
	logic [3:0] ozn_pts_q;
	logic [4:0] hgt_pts_q;
	logic signed [31:0] cutoff_q;

	// stores
	logic signed [31:0] ang_q [MAX_ANGLE_POINTS];
	logic signed [31:0] alb_q [MAX_ALBEDO_POINTS];
	logic signed [31:0] ozn_q [MAX_OZONE_POINTS];
	logic signed [31:0] hgt_q [MAX_HEIGHT_POINTS];
	logic [NUM_TABLES-1:0] written_q;

	// sequencer
	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [1:0] axis_q;
	logic [IDX_W-1:0] k_q;
	logic signed [31:0] prev_q;
	logic [TW-1:0] stride_q [4];
	logic [TW-1:0] off_lo_q [4];
	logic [TW-1:0] off_hi_q [4];
	logic [WB:0] w_q [4];
	logic [MAW-1:0] base_q;
	logic [3:0] m_q;
	logic [1:0] lvl_q;
	logic signed [31:0] x_q;
	logic signed [31:0] pval_q [4];
	logic [3:0] pend_q;
	logic done_q;
	result_t result_q;

	logic [CNT_W-1:0] ns, na, no, nh, ncur;
	logic [IDX_W-1:0] kmax;
	logic signed [31:0] axv, vcur;
	logic signed [32:0] diff, den;
	logic [TW-1:0] stride_cur;
	logic accept, is_query, cut_hit, tab_ok, scan_stop;
	logic [TSW-1:0] tsel_x;
	logic tab_we;
	logic [MAW-1:0] waddr, raddr;
	logic [31:0] rdata;
	logic div_go, div_done, blend_go, blend_done;
	logic [WB-1:0] quo;
	logic signed [31:0] blend_y;
	logic [TW-1:0] off_sum;

	assign ns = clamp_count(ang_pts_q, MAX_ANGLE_POINTS);
	assign na = clamp_count({2'b0, alb_pts_q}, MAX_ALBEDO_POINTS);
	assign no = clamp_count({1'b0, ozn_pts_q}, MAX_OZONE_POINTS);
	assign nh = clamp_count(hgt_pts_q, MAX_HEIGHT_POINTS);

	assign accept   = start && !busy;
	assign is_query = cmd.action == ACT_QUERY;
	assign tsel_x   = TSW'(cmd.table_select);
	assign cut_hit  = cmd.angle_coord >= cutoff_q;
	assign tab_ok   = (int'(cmd.table_select) < NUM_TABLES) && written_q[tsel_x];
	assign tab_we   = accept && cmd.action == ACT_TABLE &&
		(int'(cmd.table_select) < NUM_TABLES) &&
		(int'(cmd.entry_index) < TABLE_SIZE);
	assign waddr = MAW'(tsel_x) * MAW'(TABLE_SIZE) + MAW'(cmd.entry_index);

	always_comb begin
		case (axis_q)
			AXIS_ANGLE: begin
				axv = ang_q[k_q[ANG_AW-1:0]];
				vcur = cmd_q.angle_coord;
				ncur = ns;
			end
			AXIS_ALBEDO: begin
				axv = alb_q[k_q[ALB_AW-1:0]];
				vcur = cmd_q.albedo_coord;
				ncur = na;
			end
			AXIS_OZONE: begin
				axv = ozn_q[k_q[OZN_AW-1:0]];
				vcur = cmd_q.ozone_coord;
				ncur = no;
			end
			default: begin
				axv = hgt_q[k_q[HGT_AW-1:0]];
				vcur = cmd_q.height_coord;
				ncur = nh;
			end
		endcase
	end

	assign stride_cur = stride_q[axis_q];
	assign kmax = IDX_W'(ncur - 1'b1);
	assign diff = 33'(vcur) - 33'(prev_q);
	assign den  = 33'(axv) - 33'(prev_q);
	assign scan_stop = (axv >= vcur) || (k_q == kmax);

	// corner bits: 3 angle, 2 albedo, 1 ozone, 0 altitude
	assign off_sum = (m_q[3] ? off_hi_q[0] : off_lo_q[0]) +
		(m_q[2] ? off_hi_q[1] : off_lo_q[1]) +
		(m_q[1] ? off_hi_q[2] : off_lo_q[2]) +
		(m_q[0] ? off_hi_q[3] : off_lo_q[3]);
	assign raddr = base_q + MAW'(off_sum);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept && is_query && !cut_hit && tab_ok) state_d = ST_FIRST;
			ST_FIRST:
				if (vcur <= axv) state_d = (axis_q == AXIS_HEIGHT) ? ST_RD : ST_FIRST;
				else state_d = ST_LAST;
			ST_LAST:
				if (vcur >= axv) state_d = (axis_q == AXIS_HEIGHT) ? ST_RD : ST_FIRST;
				else state_d = ST_SCAN;
			ST_SCAN:
				if (scan_stop) begin
					if (diff >= den) state_d = (axis_q == AXIS_HEIGHT) ? ST_RD : ST_FIRST;
					else state_d = ST_DIV;
				end
			ST_DIV:
				if (div_done) state_d = (axis_q == AXIS_HEIGHT) ? ST_RD : ST_FIRST;
			ST_RD:    state_d = ST_WAIT;
			ST_WAIT:  state_d = ST_MERGE;
			ST_MERGE: state_d = pend_q[lvl_q] ? ST_BLEND : ST_RD;
			ST_BLEND:
				if (blend_done) state_d = (lvl_q == 2'd3) ? ST_IDLE : ST_MERGE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy     = state_q != ST_IDLE;
		div_go   = (state_q == ST_SCAN) && scan_stop && !(diff >= den);
		blend_go = (state_q == ST_MERGE) && pend_q[lvl_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			written_q <= '0;
			ang_pts_q <= RST_ANGLE_POINTS;
			alb_pts_q <= RST_ALBEDO_POINTS;
			ozn_pts_q <= RST_OZONE_POINTS;
			hgt_pts_q <= RST_HEIGHT_POINTS;
			cutoff_q  <= RST_ANGLE_CUTOFF;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_POINTS:  ang_pts_q <= cfg_data[4:0];
					REG_ALBEDO_POINTS: alb_pts_q <= cfg_data[2:0];
					REG_OZONE_POINTS:  ozn_pts_q <= cfg_data[3:0];
					REG_HEIGHT_POINTS: hgt_pts_q <= cfg_data[4:0];
					REG_ANGLE_CUTOFF:  cutoff_q  <= cfg_data;
					default: ;
				endcase
			end
			if (tab_we) written_q[tsel_x] <= 1'b1;
			if (accept && is_query && (cut_hit || !tab_ok)) done_q <= 1'b1;
			if (state_q == ST_BLEND && blend_done && lvl_q == 2'd3) done_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept && cmd.action == ACT_AXIS) begin
			case (cmd.axis_select)
				AXIS_ANGLE:
					if (int'(cmd.entry_index) < MAX_ANGLE_POINTS)
						ang_q[cmd.entry_index[ANG_AW-1:0]] <= cmd.write_value;
				AXIS_ALBEDO:
					if (int'(cmd.entry_index) < MAX_ALBEDO_POINTS)
						alb_q[cmd.entry_index[ALB_AW-1:0]] <= cmd.write_value;
				AXIS_OZONE:
					if (int'(cmd.entry_index) < MAX_OZONE_POINTS)
						ozn_q[cmd.entry_index[OZN_AW-1:0]] <= cmd.write_value;
				default:
					if (int'(cmd.entry_index) < MAX_HEIGHT_POINTS)
						hgt_q[cmd.entry_index[HGT_AW-1:0]] <= cmd.write_value;
			endcase
		end
		case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				axis_q <= AXIS_ANGLE;
				k_q <= '0;
				base_q <= MAW'(tsel_x) * MAW'(TABLE_SIZE);
				stride_q[0] <= TW'(1);
				stride_q[1] <= TW'(ns);
				stride_q[2] <= TW'(ns) * TW'(na);
				stride_q[3] <= TW'(ns) * TW'(na) * TW'(no);
				if (accept && is_query) begin
					result_q.interp_value <= '0;
					result_q.status <= cut_hit ? STAT_CUTOFF : STAT_NOTABLE;
				end
			end
			ST_FIRST: begin
				if (vcur <= axv) begin
					off_lo_q[axis_q] <= '0;
					off_hi_q[axis_q] <= '0;
					w_q[axis_q] <= '0;
					axis_q <= axis_q + 1'b1;
					k_q <= '0;
				end else begin
					prev_q <= axv;
					k_q <= kmax;
				end
			end
			ST_LAST: begin
				if (vcur >= axv) begin
					off_lo_q[axis_q] <= TW'(kmax - 1'b1) * stride_cur;
					off_hi_q[axis_q] <= TW'(kmax) * stride_cur;
					w_q[axis_q] <= W_ONE;
					axis_q <= axis_q + 1'b1;
					k_q <= '0;
				end else begin
					k_q <= IDX_W'(1);
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					off_lo_q[axis_q] <= TW'(k_q - 1'b1) * stride_cur;
					off_hi_q[axis_q] <= TW'(k_q) * stride_cur;
					if (diff >= den) begin
						w_q[axis_q] <= W_ONE;
						axis_q <= axis_q + 1'b1;
						k_q <= '0;
					end
				end else begin
					prev_q <= axv;
					k_q <= k_q + 1'b1;
				end
				m_q <= '0;
				lvl_q <= '0;
				pend_q <= '0;
			end
			ST_DIV: begin
				if (div_done) begin
					w_q[axis_q] <= {1'b0, quo};
					axis_q <= axis_q + 1'b1;
					k_q <= '0;
				end
			end
			ST_WAIT: begin
				x_q <= rdata;
				lvl_q <= '0;
			end
			ST_MERGE: begin
				if (!pend_q[lvl_q]) begin
					pval_q[lvl_q] <= x_q;
					pend_q[lvl_q] <= 1'b1;
					m_q <= m_q + 1'b1;
				end
			end
			ST_BLEND: begin
				if (blend_done) begin
					x_q <= blend_y;
					pend_q[lvl_q] <= 1'b0;
					lvl_q <= lvl_q + 1'b1;
					if (lvl_q == 2'd3) begin
						result_q.interp_value <= blend_y;
						result_q.status <= STAT_OK;
					end
				end
			end
			default: ;
		endcase
		// the first-point, last-point and division states also reset the corner walk
		if (state_q == ST_FIRST || state_q == ST_LAST || state_q == ST_DIV) begin
			m_q <= '0;
			lvl_q <= '0;
			pend_q <= '0;
		end
	end

	qti_div #(.WB(WB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (diff),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	// level 0 blends altitude, then ozone, albedo, angle
	qti_blend #(.WB(WB)) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (blend_go),
		.a      (pval_q[lvl_q]),
		.b      (x_q),
		.w      (w_q[2'd3 - lvl_q]),
		.done   (blend_done),
		.y      (blend_y)
	);

	qti_ram #(.DEPTH(MEM_DEPTH), .AW(MAW)) u_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (waddr),
		.wdata (cmd.write_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |-> result.interp_value == 32'sd0)
		else $error("nonzero value with failure status");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.action != ACT_QUERY) |=> (!busy && !done))
		else $error("write transaction produced a result or busy");
endmodule
